// File: rtl/mtrf_pkg.sv
// Package: shared types, constants and the function code table of the request framer.
package mtrf_pkg;

  localparam logic [2:0] OP_WR_COIL  = 3'd4;
  localparam logic [2:0] OP_WR_REG   = 3'd5;
  localparam logic [2:0] OP_WR_COILS = 3'd6;
  localparam logic [2:0] OP_WR_REGS  = 3'd7;

  localparam logic [3:0] HDR_SINGLE_N = 4'd12;
  localparam logic [3:0] HDR_MULTI_N  = 4'd13;

  localparam logic [7:0] UNIT_ID_RST  = 8'h01;
  localparam logic [7:0] COIL_ON_BYTE = 8'hFF;
  localparam logic [15:0] LEN_SINGLE  = 16'd6;
  localparam logic [15:0] LEN_MULTI   = 16'd7;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  // One queued piece of output: optional header, then zero to two tail bytes.
  typedef struct packed {
    logic [3:0]  hdr_n;
    logic [1:0]  tail_n;
    logic        end_f;
    logic [7:0]  unit;
    logic [7:0]  func;
    logic [15:0] addr;
    logic [15:0] len;
    logic [15:0] word;
    logic [7:0]  bcnt;
    logic [15:0] tail;
  } job_t;

  function automatic logic [7:0] func_code(input logic [2:0] op);
    logic [7:0] c;
    unique case (op)
      3'd0: c = 8'h01;
      3'd1: c = 8'h02;
      3'd2: c = 8'h03;
      3'd3: c = 8'h04;
      3'd4: c = 8'h05;
      3'd5: c = 8'h06;
      3'd6: c = 8'h0F;
      3'd7: c = 8'h10;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/mtrf_if.sv
// Interfaces: request element channel and frame byte channel.
interface mtrf_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [15:0] start_address;
  logic [10:0] quantity;
  logic [15:0] data_value;
  logic        last_element;

  modport source (output valid, op, start_address, quantity, data_value, last_element,
                  input ready);
  modport sink (input valid, op, start_address, quantity, data_value, last_element,
                output ready);
endinterface

interface mtrf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_end;

  modport source (output valid, frame_byte, frame_end, input ready);
  modport sink (input valid, frame_byte, frame_end, output ready);
endinterface

// File: rtl/mtrf_queue.sv
// Job queue between the element front end and the byte sequencer.
module mtrf_queue
  import mtrf_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t pop_job,
  output logic full,
  output logic empty
);

  job_t           mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]   cnt_r, cnt_nxt;

  assign full    = (cnt_r == (QAW+1)'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign pop_job = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (QAW+1)'(push) - (QAW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// File: rtl/mtrf_front.sv
// Front end: takes request elements, tracks frame state and builds byte jobs.
module mtrf_front
  import mtrf_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic [7:0] cfg_data,
  mtrf_in_if.sink in_ch,
  input  logic q_full,
  output logic q_push,
  output job_t q_job
);

  logic [7:0]  unit_r, unit_nxt;
  logic        inside_r, inside_nxt;
  logic [10:0] idx_r, idx_nxt;
  logic [7:0]  pack_r, pack_nxt;

  logic        acc;
  logic [11:0] data_len;
  logic [10:0] idx_cur;
  logic [7:0]  pack_cur;
  logic [7:0]  pack_new;
  logic [2:0]  bitpos;
  job_t        job;

  assign in_ch.ready = !q_full;
  assign acc = in_ch.valid && in_ch.ready;
  assign unit_nxt = cfg_we ? cfg_data : unit_r;

  always_comb begin
    data_len = (in_ch.op == OP_WR_COILS) ?
               ((12'(in_ch.quantity) + 12'd7) >> 3) : {in_ch.quantity, 1'b0};
    idx_cur  = inside_r ? idx_r : '0;
    pack_cur = inside_r ? pack_r : '0;
    bitpos   = idx_cur[2:0];
    pack_new = pack_cur | ((in_ch.data_value != '0) ? (8'd1 << bitpos) : 8'd0);

    job        = '0;
    job.unit   = unit_r;
    job.func   = func_code(in_ch.op);
    job.addr   = in_ch.start_address;
    job.len    = (in_ch.op >= OP_WR_COILS) ? (LEN_MULTI + 16'(data_len)) : LEN_SINGLE;
    job.bcnt   = data_len[7:0];
    job.word   = 16'(in_ch.quantity);
    inside_nxt = inside_r;
    idx_nxt    = idx_r;
    pack_nxt   = pack_r;

    if (!inside_r && in_ch.op < OP_WR_COILS) begin
      job.hdr_n = HDR_SINGLE_N;
      job.end_f = 1'b1;
      if (in_ch.op == OP_WR_COIL) begin
        job.word = {(in_ch.data_value != '0) ? COIL_ON_BYTE : 8'h00, 8'h00};
      end else if (in_ch.op == OP_WR_REG) begin
        job.word = in_ch.data_value;
      end
    end else begin
      job.hdr_n = inside_r ? 4'd0 : HDR_MULTI_N;
      if (in_ch.op == OP_WR_COILS) begin
        if (bitpos == 3'd7 || in_ch.last_element) begin
          job.tail_n = 2'd1;
          job.tail   = {pack_new, 8'h00};
          pack_nxt   = '0;
        end else begin
          pack_nxt   = pack_new;
        end
      end else begin
        job.tail_n = 2'd2;
        job.tail   = in_ch.data_value;
      end
      idx_nxt    = idx_cur + 11'd1;
      inside_nxt = 1'b1;
      if (in_ch.last_element) begin
        job.end_f  = 1'b1;
        inside_nxt = 1'b0;
        idx_nxt    = '0;
        pack_nxt   = '0;
      end
    end
  end

  assign q_job  = job;
  assign q_push = acc && ((job.hdr_n != 4'd0) || (job.tail_n != 2'd0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_r   <= UNIT_ID_RST;
      inside_r <= 1'b0;
      idx_r    <= '0;
      pack_r   <= '0;
    end else begin
      unit_r <= unit_nxt;
      if (acc) begin
        inside_r <= inside_nxt;
        idx_r    <= idx_nxt;
        pack_r   <= pack_nxt;
      end
    end
  end

endmodule

// File: rtl/mtrf_back.sv
// Back end: walks each queued job and sends one frame byte per beat.
module mtrf_back
  import mtrf_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic q_empty,
  input  job_t q_job,
  output logic q_pop,
  mtrf_out_if.source out_ch
);

  job_t       job_r, job_nxt;
  logic       busy_r, busy_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic       ov_r, ov_nxt;
  logic [7:0] ob_r, ob_nxt;
  logic       oe_r, oe_nxt;

  logic       adv;
  logic       last_b;
  logic [3:0] total;
  logic [7:0] sel;

  assign out_ch.valid      = ov_r;
  assign out_ch.frame_byte = ob_r;
  assign out_ch.frame_end  = oe_r;

  always_comb begin
    total  = job_r.hdr_n + 4'(job_r.tail_n);
    last_b = (cnt_r == total - 4'd1);
    adv    = busy_r && (!ov_r || out_ch.ready);

    if (cnt_r < job_r.hdr_n) begin
      unique case (cnt_r)
        4'd0:    sel = 8'h00;
        4'd1:    sel = 8'h01;
        4'd2:    sel = 8'h00;
        4'd3:    sel = 8'h00;
        4'd4:    sel = job_r.len[15:8];
        4'd5:    sel = job_r.len[7:0];
        4'd6:    sel = job_r.unit;
        4'd7:    sel = job_r.func;
        4'd8:    sel = job_r.addr[15:8];
        4'd9:    sel = job_r.addr[7:0];
        4'd10:   sel = job_r.word[15:8];
        4'd11:   sel = job_r.word[7:0];
        4'd12:   sel = job_r.bcnt;
        default: sel = 8'h00;
      endcase
    end else begin
      sel = (cnt_r == job_r.hdr_n) ? job_r.tail[15:8] : job_r.tail[7:0];
    end

    ov_nxt   = ov_r && !out_ch.ready;
    ob_nxt   = ob_r;
    oe_nxt   = oe_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    job_nxt  = job_r;
    q_pop    = 1'b0;

    if (adv) begin
      ov_nxt  = 1'b1;
      ob_nxt  = sel;
      oe_nxt  = job_r.end_f && last_b;
      cnt_nxt = cnt_r + 4'd1;
      if (last_b) begin
        busy_nxt = 1'b0;
      end
    end

    if ((!busy_r || (adv && last_b)) && !q_empty) begin
      q_pop    = 1'b1;
      job_nxt  = q_job;
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    ob_r  <= ob_nxt;
    oe_r  <= oe_nxt;
  end

endmodule

// File: rtl/modbus_tcp_request_framer.sv
// Top level: Modbus TCP request framer, element stream in, frame bytes out.
// When idle, a job's first byte passes the queue, job register and byte register.
// Throughput: one frame byte per cycle, set by the sequencer, while out ready holds;
//   a single request is 12 bytes, a register element 2, a coil element at most 1.
// Elements are taken every cycle while the 4-entry job queue has room.
// Reset (sync, active low): frame state, queue and output clear; unit_id returns to 1.
module modbus_tcp_request_framer
  import mtrf_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic [7:0] cfg_data,
  mtrf_in_if.sink in_ch,
  mtrf_out_if.source out_ch
);

  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  job_t q_wjob;
  job_t q_rjob;

  mtrf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (q_wjob)
  );

  mtrf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_wjob),
    .pop      (q_pop),
    .pop_job  (q_rjob),
    .full     (q_full),
    .empty    (q_empty)
  );

  mtrf_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_job   (q_rjob),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
